// File: sv/plsd_pkg.sv
// Shared types, codes and helpers for the progressive layer stream deframer.
`default_nettype none
package plsd_pkg;

  localparam int CODELEN_BYTES_DEF = 16;
  localparam int LAYER_CAP_DEF     = 32;
  localparam int MAX_CHANNELS_DEF  = 3;

  localparam logic [31:0] BLOCK_MARKER = 32'hffffffff;
  localparam logic [31:0] LAYER_MARKER = 32'hfffffffe;
  localparam logic [31:0] DIM_MAX      = 32'h7fffffff;
  localparam logic [31:0] QUANT_MAX    = 32'h7f7fffff;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_CODELEN = 3'd1,
    K_DOM     = 3'd2,
    K_RUN     = 3'd3,
    K_REF     = 3'd4,
    K_FIELD   = 3'd5,
    K_MARKER  = 3'd6,
    K_DISCARD = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    E_OK        = 4'd0,
    E_MAGIC     = 4'd1,
    E_HEADER    = 4'd2,
    E_COUNTS    = 4'd3,
    E_BLOCK     = 4'd4,
    E_BLOCK_MK  = 4'd5,
    E_LAYER_MK  = 4'd6,
    E_TRAILING  = 4'd7,
    E_TRUNCATED = 4'd8
  } err_t;

  typedef logic [2:0][5:0] lpc_t;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic [1:0] payload_channel;
    logic [4:0] payload_layer;
    logic       header_ready;
    logic       layer_done;
    logic       stream_done;
    logic [3:0] error_code;
  } res_t;

  typedef struct packed {
    logic       found;
    logic [1:0] ch;
  } seek_t;

  // First channel at or above start that still has a block in this layer.
  function automatic seek_t seek_block(input logic [2:0] start, input logic [5:0] layer,
                                       input logic [1:0] ctot, input lpc_t lpc);
    seek_t s;
    s.found = 1'b0;
    s.ch    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (!s.found && 3'(i) >= start && 2'(i) < ctot && layer < lpc[i]) begin
        s.found = 1'b1;
        s.ch    = 2'(i);
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: sv/plsd_parse.sv
// Byte parser: field assembly, header and block checks, sticky error.
`default_nettype none
module plsd_parse #(
  parameter int CODELEN_BYTES = plsd_pkg::CODELEN_BYTES_DEF,
  parameter int LAYER_CAP     = plsd_pkg::LAYER_CAP_DEF,
  parameter int MAX_CHANNELS  = plsd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic           acc,
  input  wire logic [7:0]     stream_byte,
  input  wire logic           end_of_stream,
  output plsd_pkg::res_t      res
);
  import plsd_pkg::*;

  localparam int CLW = $clog2(CODELEN_BYTES) + 1;

  typedef enum logic [25:0] {
    PH_MAGIC      = 26'h0000001,
    PH_VERSION    = 26'h0000002,
    PH_WIDTH      = 26'h0000004,
    PH_HEIGHT     = 26'h0000008,
    PH_CHANNELS   = 26'h0000010,
    PH_LEVELS     = 26'h0000020,
    PH_QUANT      = 26'h0000040,
    PH_CODELEN    = 26'h0000080,
    PH_DECLARED   = 26'h0000100,
    PH_CHCOUNT    = 26'h0000200,
    PH_TOKENS     = 26'h0000400,
    PH_COMMANDS   = 26'h0000800,
    PH_DOM_BITS   = 26'h0001000,
    PH_DOM_BYTES  = 26'h0002000,
    PH_DOM_DATA   = 26'h0004000,
    PH_RUN_BITS   = 26'h0008000,
    PH_RUN_BYTES  = 26'h0010000,
    PH_RUN_DATA   = 26'h0020000,
    PH_SYMBOLS    = 26'h0040000,
    PH_MODE       = 26'h0080000,
    PH_REF_BITS   = 26'h0100000,
    PH_REF_BYTES  = 26'h0200000,
    PH_REF_DATA   = 26'h0400000,
    PH_BLOCK_MARK = 26'h0800000,
    PH_LAYER_MARK = 26'h1000000,
    PH_DONE       = 26'h2000000
  } phase_t;

  typedef enum logic [1:0] {
    R_MAGIC   = 2'd0,
    R_VERSION = 2'd1,
    R_LEVELS  = 2'd2,
    R_MODE    = 2'd3
  } reg_idx_t;

  logic [31:0] magic_r, version_r;
  logic [7:0]  max_lvl_r, max_mode_r;

  phase_t      ph_r, ph_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [23:0] fv_r, fv_nxt;
  logic [CLW-1:0] cl_r, cl_nxt;
  logic [30:0] wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic [61:0] plane_r;
  logic [1:0]  ctot_r, ctot_nxt;
  lpc_t        lpc_r, lpc_nxt;
  logic [5:0]  decl_r, decl_nxt, rmax_r, rmax_nxt, lay_r, lay_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [31:0] rem_r, rem_nxt, saved_r, saved_nxt;
  logic [3:0]  err_r, err_nxt;

  logic [31:0] word;
  logic [3:0]  werr;
  logic [5:0]  lay_inc, rmax_up;
  seek_t       sk;
  logic        hr, ld;
  logic [2:0]  kind;
  logic [1:0]  och;
  logic [4:0]  olay;

  assign word    = {stream_byte, fv_r};
  assign lay_inc = lay_r + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      version_r  <= 32'd1;
      max_lvl_r  <= 8'd8;
      max_mode_r <= 8'd1;
    end else if (cfg_we && cfg_index[7:2] == 6'd0) begin
      case (reg_idx_t'(cfg_index[1:0]))
        R_MAGIC:   magic_r    <= cfg_data;
        R_VERSION: version_r  <= cfg_data;
        R_LEVELS:  max_lvl_r  <= cfg_data[7:0];
        R_MODE:    max_mode_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ph_nxt = ph_r; idx_nxt = idx_r; fv_nxt = fv_r; cl_nxt = cl_r;
    wid_nxt = wid_r; hgt_nxt = hgt_r; ctot_nxt = ctot_r; lpc_nxt = lpc_r;
    decl_nxt = decl_r; rmax_nxt = rmax_r; lay_nxt = lay_r; ch_nxt = ch_r;
    rem_nxt = rem_r; saved_nxt = saved_r; err_nxt = err_r;
    kind = K_DISCARD; och = 2'd0; olay = 5'd0; hr = 1'b0; ld = 1'b0;
    werr = E_OK; sk = '0; rmax_up = '0;

    if (err_r != E_OK) begin
      // discard
    end else if (ph_r == PH_DONE) begin
      err_nxt = E_TRAILING;
    end else if (ph_r == PH_CODELEN) begin
      kind = K_CODELEN;
      if (cl_r == CLW'(CODELEN_BYTES - 1)) begin
        cl_nxt = '0;
        ph_nxt = PH_DECLARED;
      end else begin
        cl_nxt = cl_r + 1'b1;
      end
    end else if (ph_r == PH_DOM_DATA || ph_r == PH_RUN_DATA || ph_r == PH_REF_DATA) begin
      kind = (ph_r == PH_DOM_DATA) ? K_DOM : (ph_r == PH_RUN_DATA) ? K_RUN : K_REF;
      och  = ch_r;
      olay = lay_r[4:0];
      rem_nxt = rem_r - 32'd1;
      if (rem_r == 32'd1)
        ph_nxt = (ph_r == PH_DOM_DATA) ? PH_RUN_BITS :
                 (ph_r == PH_RUN_DATA) ? PH_SYMBOLS : PH_BLOCK_MARK;
    end else begin
      if (ph_r == PH_MAGIC || ph_r == PH_VERSION || ph_r == PH_WIDTH ||
          ph_r == PH_HEIGHT || ph_r == PH_CHANNELS || ph_r == PH_LEVELS ||
          ph_r == PH_QUANT || ph_r == PH_DECLARED || ph_r == PH_CHCOUNT) begin
        kind = K_HEADER;
      end else begin
        kind = (ph_r == PH_BLOCK_MARK || ph_r == PH_LAYER_MARK) ? K_MARKER : K_FIELD;
        och  = (ph_r == PH_LAYER_MARK) ? 2'd0 : ch_r;
        olay = lay_r[4:0];
      end
      if (idx_r != 2'd3) begin
        case (idx_r)
          2'd0:    fv_nxt[7:0]   = stream_byte;
          2'd1:    fv_nxt[15:8]  = stream_byte;
          default: fv_nxt[23:16] = stream_byte;
        endcase
        idx_nxt = idx_r + 2'd1;
      end else begin
        fv_nxt  = '0;
        idx_nxt = 2'd0;
        case (ph_r)
          PH_MAGIC: begin
            if (word != magic_r) werr = E_MAGIC;
            else ph_nxt = PH_VERSION;
          end
          PH_VERSION: begin
            if (word != version_r) werr = E_HEADER;
            else ph_nxt = PH_WIDTH;
          end
          PH_WIDTH: begin
            if (word == 32'd0 || word > DIM_MAX) werr = E_HEADER;
            else begin wid_nxt = word[30:0]; ph_nxt = PH_HEIGHT; end
          end
          PH_HEIGHT: begin
            if (word == 32'd0 || word > DIM_MAX) werr = E_HEADER;
            else begin hgt_nxt = word[30:0]; ph_nxt = PH_CHANNELS; end
          end
          PH_CHANNELS: begin
            if ((word != 32'd1 && word != 32'd3) || word > 32'(MAX_CHANNELS))
              werr = E_HEADER;
            else begin ctot_nxt = word[1:0]; ph_nxt = PH_LEVELS; end
          end
          PH_LEVELS: begin
            if (word == 32'd0 || word > {24'd0, max_lvl_r}) werr = E_HEADER;
            else ph_nxt = PH_QUANT;
          end
          PH_QUANT: begin
            if (word == 32'd0 || word > QUANT_MAX) werr = E_HEADER;
            else begin cl_nxt = '0; ph_nxt = PH_CODELEN; end
          end
          PH_DECLARED: begin
            if (word > 32'(LAYER_CAP)) werr = E_COUNTS;
            else begin
              decl_nxt = word[5:0]; rmax_nxt = '0; ch_nxt = 2'd0; ph_nxt = PH_CHCOUNT;
            end
          end
          PH_CHCOUNT: begin
            if (word > {26'd0, decl_r}) werr = E_COUNTS;
            else begin
              if (ch_r != 2'd3) lpc_nxt[ch_r] = word[5:0];
              rmax_up  = (word[5:0] > rmax_r) ? word[5:0] : rmax_r;
              rmax_nxt = rmax_up;
              if ({1'b0, ch_r} + 3'd1 < {1'b0, ctot_r}) begin
                ch_nxt = ch_r + 2'd1;
              end else if (rmax_up != decl_r) begin
                werr = E_COUNTS;
              end else begin
                hr = 1'b1; lay_nxt = '0; ch_nxt = 2'd0;
                if (decl_r == 6'd0) ph_nxt = PH_DONE;
                else begin
                  sk = seek_block(3'd0, 6'd0, ctot_r, lpc_nxt);
                  ch_nxt = sk.ch;
                  ph_nxt = sk.found ? PH_TOKENS : PH_LAYER_MARK;
                end
              end
            end
          end
          PH_TOKENS: begin
            if ({30'd0, word} > plane_r) werr = E_BLOCK;
            else begin saved_nxt = word; ph_nxt = PH_COMMANDS; end
          end
          PH_COMMANDS: begin
            if (word > saved_r) werr = E_BLOCK;
            else ph_nxt = PH_DOM_BITS;
          end
          PH_DOM_BITS, PH_RUN_BITS, PH_REF_BITS: begin
            saved_nxt = word;
            ph_nxt = (ph_r == PH_DOM_BITS) ? PH_DOM_BYTES :
                     (ph_r == PH_RUN_BITS) ? PH_RUN_BYTES : PH_REF_BYTES;
          end
          PH_DOM_BYTES, PH_RUN_BYTES, PH_REF_BYTES: begin
            if ({3'd0, saved_r} > {word, 3'd0}) werr = E_BLOCK;
            else begin
              rem_nxt = word;
              if (word == 32'd0)
                ph_nxt = (ph_r == PH_DOM_BYTES) ? PH_RUN_BITS :
                         (ph_r == PH_RUN_BYTES) ? PH_SYMBOLS : PH_BLOCK_MARK;
              else
                ph_nxt = (ph_r == PH_DOM_BYTES) ? PH_DOM_DATA :
                         (ph_r == PH_RUN_BYTES) ? PH_RUN_DATA : PH_REF_DATA;
            end
          end
          PH_SYMBOLS: begin
            if ({30'd0, word} > plane_r) werr = E_BLOCK;
            else ph_nxt = PH_MODE;
          end
          PH_MODE: begin
            if (word > {24'd0, max_mode_r}) werr = E_BLOCK;
            else ph_nxt = PH_REF_BITS;
          end
          PH_BLOCK_MARK: begin
            if (word != BLOCK_MARKER) werr = E_BLOCK_MK;
            else begin
              sk = seek_block({1'b0, ch_r} + 3'd1, lay_r, ctot_r, lpc_r);
              ch_nxt = sk.ch;
              ph_nxt = sk.found ? PH_TOKENS : PH_LAYER_MARK;
            end
          end
          PH_LAYER_MARK: begin
            if (word != LAYER_MARKER) werr = E_LAYER_MK;
            else begin
              ld = 1'b1; lay_nxt = lay_inc; ch_nxt = 2'd0;
              if (lay_inc >= decl_r) ph_nxt = PH_DONE;
              else begin
                sk = seek_block(3'd0, lay_inc, ctot_r, lpc_r);
                ch_nxt = sk.ch;
                ph_nxt = sk.found ? PH_TOKENS : PH_LAYER_MARK;
              end
            end
          end
          default: ;
        endcase
        if (werr != E_OK) begin
          err_nxt = werr; hr = 1'b0; ld = 1'b0;
        end
      end
    end
    if (end_of_stream && err_nxt == E_OK && ph_nxt != PH_DONE) err_nxt = E_TRUNCATED;
  end

  assign res.byte_kind       = kind;
  assign res.payload_channel = och;
  assign res.payload_layer   = olay;
  assign res.header_ready    = hr;
  assign res.layer_done      = ld;
  assign res.stream_done     = (ph_nxt == PH_DONE) && (err_nxt == E_OK);
  assign res.error_code      = err_nxt;

  // product is taken from registered dimensions; first use is many beats later
  always_ff @(posedge clk) begin
    plane_r <= {31'd0, wid_r} * {31'd0, hgt_r};
    if (acc) begin
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      rem_r   <= rem_nxt;
      saved_r <= saved_nxt;
    end
    if (!rst_n) begin
      ph_r <= PH_MAGIC; idx_r <= '0; cl_r <= '0; ctot_r <= '0; lpc_r <= '0;
      decl_r <= '0; rmax_r <= '0; lay_r <= '0; ch_r <= '0; err_r <= '0; fv_r <= '0;
    end else if (acc) begin
      ph_r <= ph_nxt; idx_r <= idx_nxt; cl_r <= cl_nxt; ctot_r <= ctot_nxt;
      lpc_r <= lpc_nxt; decl_r <= decl_nxt; rmax_r <= rmax_nxt; lay_r <= lay_nxt;
      ch_r <= ch_nxt; err_r <= err_nxt; fv_r <= fv_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/plsd_outq.sv
// Two-entry result buffer between the parser and the output channel.
`default_nettype none
module plsd_outq (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire plsd_pkg::res_t din,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output plsd_pkg::res_t dout
);
  import plsd_pkg::*;

  res_t       q0_r, q1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign dout      = q0_r;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (cnt_r == 2'd1) q0_r <= din;
      else begin q0_r <= q1_r; q1_r <= din; end
    end else if (pop) begin
      q0_r <= q1_r;
    end else if (push) begin
      if (cnt_r == 2'd0) q0_r <= din;
      else q1_r <= din;
    end
    if (!rst_n) cnt_r <= 2'd0;
    else if (push && !pop) cnt_r <= cnt_r + 2'd1;
    else if (pop && !push) cnt_r <= cnt_r - 2'd1;
  end

endmodule
`default_nettype wire

// File: sv/progressive_layer_stream_deframer.sv
// Top level of the progressive layer stream deframer.
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | stream_byte, end_of_stream
//   out_    | output    | out_valid/out_stall| kind, channel, layer, flags, error
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One byte per cycle unless in_stall; each result is registered in the buffer.
// A two-beat result buffer lets input continue while one result waits.
// in_stall rises only when both buffer entries are held.
// Synchronous reset restores the register defaults and clears any error.
`default_nettype none
module progressive_layer_stream_deframer #(
  parameter int CODELEN_BYTES = plsd_pkg::CODELEN_BYTES_DEF,
  parameter int LAYER_CAP     = plsd_pkg::LAYER_CAP_DEF,
  parameter int MAX_CHANNELS  = plsd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_byte_kind,
  output logic [1:0]       out_payload_channel,
  output logic [4:0]       out_payload_layer,
  output logic             out_header_ready,
  output logic             out_layer_done,
  output logic             out_stream_done,
  output logic [3:0]       out_error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import plsd_pkg::*;

  res_t res, dout;
  logic acc, full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign acc       = in_valid && !full;

  plsd_parse #(
    .CODELEN_BYTES(CODELEN_BYTES), .LAYER_CAP(LAYER_CAP), .MAX_CHANNELS(MAX_CHANNELS)
  ) u_parse (
    .clk, .rst_n, .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data, .acc,
    .stream_byte(in_stream_byte), .end_of_stream(in_end_of_stream), .res
  );

  plsd_outq u_outq (
    .clk, .rst_n, .push(acc), .din(res), .full, .out_valid, .out_stall, .dout
  );

  assign out_byte_kind       = dout.byte_kind;
  assign out_payload_channel = dout.payload_channel;
  assign out_payload_layer   = dout.payload_layer;
  assign out_header_ready    = dout.header_ready;
  assign out_layer_done      = dout.layer_done;
  assign out_stream_done     = dout.stream_done;
  assign out_error_code      = dout.error_code;

endmodule
`default_nettype wire

// File: sv/plsd_checker.sv
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module plsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_byte_kind,
  input wire logic [1:0] out_payload_channel,
  input wire logic       out_header_ready,
  input wire logic       out_layer_done,
  input wire logic [3:0] out_error_code
);
  import plsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == E_OK |-> out_byte_kind != K_DISCARD)
    else $error("discarded beat without error");

  // an end flag on the same byte may still raise the truncation code
  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_ready |-> out_byte_kind == K_HEADER)
    else $error("header ready on a bad beat");

  a_layer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layer_done |->
      out_byte_kind == K_MARKER && out_payload_channel == 2'd0)
    else $error("layer done on a bad beat");

endmodule

bind progressive_layer_stream_deframer plsd_checker u_plsd_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_byte_kind, .out_payload_channel,
  .out_header_ready, .out_layer_done, .out_error_code
);
`default_nettype wire
